/* sv/plyf_pkg.sv */
package plyf_pkg;

    localparam int unsigned SqSide   = 5;
    localparam int unsigned SqCells  = 25;
    localparam int unsigned Alpha    = 26;
    localparam int unsigned LetterW  = 5;
    localparam int unsigned CharW    = 7;
    localparam int unsigned KeyW     = 60;
    localparam int unsigned CfgIdxW  = 8;

    localparam logic [LetterW-1:0] LETTER_I    = 5'd8;
    localparam logic [LetterW-1:0] LETTER_J    = 5'd9;
    localparam logic [LetterW-1:0] LETTER_LAST = 5'd25;
    localparam logic [LetterW-1:0] CELLS_MAX   = 5'd25;
    localparam logic [LetterW-1:0] KEY_HALF    = 5'd12;

    localparam logic [CharW-1:0] UPPER_A = 7'd65;
    localparam logic [CharW-1:0] UPPER_Z = 7'd90;
    localparam logic [CharW-1:0] LOWER_A = 7'd97;
    localparam logic [CharW-1:0] LOWER_Z = 7'd122;

    localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_KEY_MID  = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_KEY_LAST = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_KEY_LEN  = 8'd3;

    typedef struct packed {
        logic               ok;
        logic               upper;
        logic [LetterW-1:0] idx;
    } letter_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } place_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_KEY   = 7'b0000010,
        ST_ALPHA = 7'b0000100,
        ST_FIXJ  = 7'b0001000,
        ST_LOOK  = 7'b0010000,
        ST_ROW   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    function automatic letter_t char_to_letter(input logic [CharW-1:0] ch);
        letter_t r;
        r = '0;
        if (ch >= UPPER_A && ch <= UPPER_Z) begin
            r.ok    = 1'b1;
            r.upper = 1'b1;
            r.idx   = LetterW'(ch - UPPER_A);
        end else if (ch >= LOWER_A && ch <= LOWER_Z) begin
            r.ok  = 1'b1;
            r.idx = LetterW'(ch - LOWER_A);
        end
        return r;
    endfunction

    // small table split of a place 0..24 into row and column
    function automatic place_t split_place(input logic [LetterW-1:0] p);
        place_t r;
        if (p >= 5'd20) begin
            r.row = 3'd4;
            r.col = 3'(p - 5'd20);
        end else if (p >= 5'd15) begin
            r.row = 3'd3;
            r.col = 3'(p - 5'd15);
        end else if (p >= 5'd10) begin
            r.row = 3'd2;
            r.col = 3'(p - 5'd10);
        end else if (p >= 5'd5) begin
            r.row = 3'd1;
            r.col = 3'(p - 5'd5);
        end else begin
            r.row = 3'd0;
            r.col = 3'(p);
        end
        return r;
    endfunction

    function automatic logic [2:0] wrap_dec(input logic [2:0] v);
        return (v == 3'd0) ? 3'(SqSide - 1) : 3'(v - 3'd1);
    endfunction

    function automatic logic [LetterW-1:0] join_place(input logic [2:0] row,
                                                      input logic [2:0] col);
        return LetterW'(row) * LetterW'(SqSide) + LetterW'(col);
    endfunction

endpackage

/* sv/plyf_ram.sv */
module plyf_ram #(
    parameter int unsigned WIDTH = 5,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* sv/playfair_pair_decrypt.sv */
// Playfair digraph decryptor. Write the keyword (letter codes 0..25, A is 0) and its
// length over the cfg channel, then stream ciphertext pairs in on s_ and read plaintext
// pairs on m_. From accept to a loaded result register a pair passes the letter-to-place
// map read, the key square read of both letters and the load of the output, which waits
// while an earlier result is held on m_. The first pair after reset or after any register
// write first runs a build pass that fills the key square and the place map one letter a
// cycle: min(key_length,25) keyword codes, then the rest of the alphabet, then a step
// that copies the place of I to J, then a new map read for the held pair. J is read as
// I, each output letter keeps the case of its input, and a pair with a character that
// is not an ASCII letter comes out unchanged.
module playfair_pair_decrypt
    import plyf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [KeyW-1:0]    cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // first_char[6:0], second_char[13:7], zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata    // plain_first[6:0], plain_second[13:7], zero
);

    state_t state_reg, state_next;

    logic [KeyW-1:0]    key_low_reg, key_mid_reg;
    logic [LetterW-1:0] key_last_reg, key_len_reg;
    logic               square_ready_reg, square_ready_next;

    logic [LetterW-1:0] n_reg, n_next;
    logic [LetterW-1:0] c_reg, c_next;
    logic [LetterW-1:0] k_reg, k_next;
    logic [Alpha-1:0]   used_reg, used_next;
    logic [LetterW-1:0] i_place_reg, i_place_next;

    logic [CharW-1:0]   ch1_reg, ch2_reg;
    letter_t            l1_reg, l2_reg;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [CharW-1:0]   out1_reg, out1_next, out2_reg, out2_next;

    logic               accept;
    letter_t            in_l1, in_l2;
    logic [LetterW-1:0] len_eff, key_sel, cand;
    logic               cand_ok;

    logic               sq_we, pl_we;
    logic [LetterW-1:0] sq_waddr, pl_waddr, sq_wdata, pl_wdata;
    logic [LetterW-1:0] pl_ra, pl_rb, pl_da, pl_db;
    logic [LetterW-1:0] sq_ra, sq_rb, sq_da, sq_db;
    place_t             p1, p2;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, out2_reg, out1_reg};

    assign in_l1 = char_to_letter(s_tdata[6:0]);
    assign in_l2 = char_to_letter(s_tdata[13:7]);

    assign len_eff = (key_len_reg > CELLS_MAX) ? CELLS_MAX : key_len_reg;

    always_comb begin
        if (n_reg < KEY_HALF) begin
            key_sel = key_low_reg[n_reg[3:0]*5 +: 5];
        end else if (n_reg < 5'd24) begin
            key_sel = key_mid_reg[4'(n_reg - KEY_HALF)*5 +: 5];
        end else begin
            key_sel = key_last_reg;
        end
    end

    // map read: from the incoming beat at accept, else from the held pair
    assign pl_ra = (state_reg == ST_IDLE) ? in_l1.idx : l1_reg.idx;
    assign pl_rb = (state_reg == ST_IDLE) ? in_l2.idx : l2_reg.idx;

    assign p1 = split_place(pl_da);
    assign p2 = split_place(pl_db);

    always_comb begin
        if (p1.col == p2.col) begin
            sq_ra = join_place(wrap_dec(p1.row), p1.col);
            sq_rb = join_place(wrap_dec(p2.row), p2.col);
        end else if (p1.row == p2.row) begin
            sq_ra = join_place(p1.row, wrap_dec(p1.col));
            sq_rb = join_place(p2.row, wrap_dec(p2.col));
        end else begin
            sq_ra = join_place(p1.row, p2.col);
            sq_rb = join_place(p2.row, p1.col);
        end
    end

    always_comb begin
        state_next        = state_reg;
        square_ready_next = square_ready_reg;
        n_next            = n_reg;
        c_next            = c_reg;
        k_next            = k_reg;
        used_next         = used_reg;
        i_place_next      = i_place_reg;
        m_tvalid_next     = m_tvalid_reg;
        out1_next         = out1_reg;
        out2_next         = out2_reg;
        sq_we             = 1'b0;
        pl_we             = 1'b0;
        sq_waddr          = k_reg;
        sq_wdata          = '0;
        pl_waddr          = '0;
        pl_wdata          = k_reg;
        cand              = key_sel;
        cand_ok           = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (square_ready_reg) begin
                        state_next = ST_ROW;
                    end else begin
                        state_next = ST_KEY;
                        n_next     = '0;
                        c_next     = '0;
                        k_next     = '0;
                        used_next  = '0;
                    end
                end
            end
            ST_KEY: begin
                if (n_reg >= len_eff) begin
                    state_next = ST_ALPHA;
                end else begin
                    n_next = n_reg + 5'd1;
                    cand   = (key_sel == LETTER_J) ? LETTER_I : key_sel;
                    // codes 26..31 are skipped like repeats
                    cand_ok = (key_sel <= LETTER_LAST) && !used_reg[cand];
                end
            end
            ST_ALPHA: begin
                cand    = c_reg;
                cand_ok = (c_reg != LETTER_J) && !used_reg[c_reg];
                c_next  = c_reg + 5'd1;
                if (c_reg == LETTER_LAST) begin
                    state_next = ST_FIXJ;
                end
            end
            ST_FIXJ: begin
                pl_we             = 1'b1;
                pl_waddr          = LETTER_J;
                pl_wdata          = i_place_reg;
                square_ready_next = 1'b1;
                state_next        = ST_LOOK;
            end
            ST_LOOK: begin
                state_next = ST_ROW;
            end
            ST_ROW: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    if (l1_reg.ok && l2_reg.ok) begin
                        out1_next = CharW'(sq_da) + (l1_reg.upper ? UPPER_A : LOWER_A);
                        out2_next = CharW'(sq_db) + (l2_reg.upper ? UPPER_A : LOWER_A);
                    end else begin
                        out1_next = ch1_reg;
                        out2_next = ch2_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cand_ok) begin
            sq_we           = 1'b1;
            sq_wdata        = cand;
            pl_we           = 1'b1;
            pl_waddr        = cand;
            used_next[cand] = 1'b1;
            k_next          = k_reg + 5'd1;
            if (cand == LETTER_I) begin
                i_place_next = k_reg;
            end
        end

        if (cfg_valid && cfg_ready && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_MID ||
                                       cfg_index == REG_KEY_LAST || cfg_index == REG_KEY_LEN)) begin
            square_ready_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            square_ready_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            key_low_reg      <= '0;
            key_mid_reg      <= '0;
            key_last_reg     <= '0;
            key_len_reg      <= '0;
        end else begin
            state_reg        <= state_next;
            square_ready_reg <= square_ready_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    REG_KEY_MID:  key_mid_reg  <= cfg_data;
                    REG_KEY_LAST: key_last_reg <= cfg_data[LetterW-1:0];
                    REG_KEY_LEN:  key_len_reg  <= cfg_data[LetterW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        c_reg       <= c_next;
        k_reg       <= k_next;
        used_reg    <= used_next;
        i_place_reg <= i_place_next;
        out1_reg    <= out1_next;
        out2_reg    <= out2_next;
        if (accept) begin
            ch1_reg <= s_tdata[6:0];
            ch2_reg <= s_tdata[13:7];
            l1_reg  <= in_l1;
            l2_reg  <= in_l2;
        end
    end

    plyf_ram #(
        .WIDTH(LetterW),
        .DEPTH(Alpha)
    ) u_place_ram (
        .aclk    (aclk),
        .we      (pl_we),
        .waddr   (pl_waddr),
        .wdata   (pl_wdata),
        .raddr_a (pl_ra),
        .raddr_b (pl_rb),
        .rdata_a (pl_da),
        .rdata_b (pl_db)
    );

    plyf_ram #(
        .WIDTH(LetterW),
        .DEPTH(SqCells)
    ) u_square_ram (
        .aclk    (aclk),
        .we      (sq_we),
        .waddr   (sq_waddr),
        .wdata   (sq_wdata),
        .raddr_a (sq_ra),
        .raddr_b (sq_rb),
        .rdata_a (sq_da),
        .rdata_b (sq_db)
    );

`ifndef SYNTHESIS
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the final decode step");

    a_square_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIXJ) |-> (k_reg == CELLS_MAX))
        else $error("key square not filled with 25 letters at end of build");

    a_ready_after_build: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIXJ && !cfg_valid) |=> square_ready_reg)
        else $error("square not marked ready after build");

    a_fast_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && square_ready_reg) |=> (state_reg == ST_ROW))
        else $error("pair with built square did not go straight to square read");
`endif

endmodule

/* dv/tb_top.sv */
module tb_top
    import plyf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 600000;
    localparam int unsigned Phases     = 12;
    localparam int unsigned PhaseItems = 96;
    localparam logic [CfgIdxW-1:0] REG_NONE = REG_KEY_LEN + 8'd1;

    class playfair_board;
        logic [KeyW-1:0]    key_low;
        logic [KeyW-1:0]    key_mid;
        logic [LetterW-1:0] key_last;
        logic [LetterW-1:0] key_len;
        logic [LetterW-1:0] square [SqCells];
        logic [LetterW-1:0] place [Alpha];
        bit                 built;
        logic [2*CharW-1:0] plain_due [$];  // {plain_second, plain_first}
        int                 mismatches;

        function new();
            key_low    = '0;
            key_mid    = '0;
            key_last   = '0;
            key_len    = '0;
            built      = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [KeyW-1:0] data);
            case (idx)
                REG_KEY_LOW: key_low = data;
                REG_KEY_MID: key_mid = data;
                REG_KEY_LAST: key_last = data[LetterW-1:0];
                REG_KEY_LEN: key_len = data[LetterW-1:0];
                default: return;
            endcase
            built = 1'b0;
        endfunction

        function void fill_square();
            bit                 taken [Alpha];
            int                 len;
            int                 cnt;
            logic [LetterW-1:0] c;
            foreach (taken[a]) taken[a] = 1'b0;
            cnt = 0;
            len = (key_len > CELLS_MAX) ? int'(SqCells) : int'(key_len);
            for (int n = 0; n < len; n++) begin
                if (n < int'(KEY_HALF))
                    c = key_low[LetterW*n +: LetterW];
                else if (n < 2 * int'(KEY_HALF))
                    c = key_mid[LetterW*(n-int'(KEY_HALF)) +: LetterW];
                else
                    c = key_last;
                // codes past Z are skipped like repeats
                if (c >= Alpha) continue;
                if (c == LETTER_J) c = LETTER_I;
                if (!taken[c] && cnt < int'(SqCells)) begin
                    taken[c] = 1'b1;
                    square[cnt] = c;
                    cnt++;
                end
            end
            for (int a = 0; a < int'(Alpha); a++) begin
                if (a != int'(LETTER_J) && !taken[a] && cnt < int'(SqCells)) begin
                    taken[a] = 1'b1;
                    square[cnt] = LetterW'(a);
                    cnt++;
                end
            end
            for (int p = 0; p < int'(SqCells); p++) place[square[p]] = LetterW'(p);
            place[LETTER_J] = place[LETTER_I];
            built = 1'b1;
        endfunction

        function int letter_of(logic [CharW-1:0] ch, output bit upper);
            upper = 1'b0;
            if (ch >= UPPER_A && ch <= UPPER_Z) begin
                upper = 1'b1;
                return int'(ch - UPPER_A);
            end
            if (ch >= LOWER_A && ch <= LOWER_Z) return int'(ch - LOWER_A);
            return -1;
        endfunction

        function void note_cipher_pair(logic [CharW-1:0] c1, logic [CharW-1:0] c2);
            int                 l1, l2, p1, p2, r1, r2, k1, k2, o1, o2;
            int                 side;
            bit                 up1, up2;
            logic [CharW-1:0]   pf, ps;
            side = int'(SqSide);
            if (!built) fill_square();
            l1 = letter_of(c1, up1);
            l2 = letter_of(c2, up2);
            if (l1 < 0 || l2 < 0) begin
                plain_due.push_back({c2, c1});
                return;
            end
            p1 = int'(place[l1]);
            p2 = int'(place[l2]);
            r1 = p1 / side;
            k1 = p1 % side;
            r2 = p2 / side;
            k2 = p2 % side;
            if (k1 == k2) begin
                o1 = ((r1 + side - 1) % side) * side + k1;
                o2 = ((r2 + side - 1) % side) * side + k2;
            end else if (r1 == r2) begin
                o1 = r1 * side + (k1 + side - 1) % side;
                o2 = r2 * side + (k2 + side - 1) % side;
            end else begin
                o1 = r1 * side + k2;
                o2 = r2 * side + k1;
            end
            pf = CharW'(square[o1]) + (up1 ? UPPER_A : LOWER_A);
            ps = CharW'(square[o2]) + (up2 ? UPPER_A : LOWER_A);
            plain_due.push_back({ps, pf});
        endfunction

        function void check_result(logic [15:0] tdata);
            logic [2*CharW-1:0] want;
            if (plain_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result beat with nothing due: first=%0d second=%0d",
                             $realtime, tdata[CharW-1:0], tdata[2*CharW-1:CharW]);
                return;
            end
            want = plain_due.pop_front();
            if (tdata[CharW-1:0] !== want[CharW-1:0] ||
                tdata[2*CharW-1:CharW] !== want[2*CharW-1:CharW]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] pair mismatch: exp %0d/%0d, got %0d/%0d",
                             $realtime, want[CharW-1:0], want[2*CharW-1:CharW],
                             tdata[CharW-1:0], tdata[2*CharW-1:CharW]);
            end
        endfunction

        function int outstanding();
            return plain_due.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [KeyW-1:0]    cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [15:0]        s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;

    playfair_board board = new();

    bit          tx_fast;
    bit          rx_fast;
    int unsigned rx_hold;
    int unsigned cycles = 0;

    playfair_pair_decrypt uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [CharW-1:0] rand_letter();
        logic [CharW-1:0] idx;
        idx = CharW'($urandom_range(0, Alpha - 1));
        return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + idx;
    endfunction

    // punctuation between the two letter ranges, or any 7-bit value
    function automatic logic [CharW-1:0] rand_other();
        if ($urandom_range(0, 1))
            return CharW'($urandom_range(UPPER_Z + 1, LOWER_A - 1));
        return CharW'($urandom_range(0, 127));
    endfunction

    task automatic program_reg(input logic [CfgIdxW-1:0] idx, input logic [KeyW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // codes 26..31 and J are legal here, junk fills unused register bits
    task automatic program_key(input logic [LetterW-1:0] codes [SqCells],
                               input logic [LetterW-1:0] len_code, input bit junk);
        logic [KeyW-1:0] low_word, mid_word, last_word, len_word;
        for (int n = 0; n < int'(KEY_HALF); n++) begin
            low_word[LetterW*n +: LetterW] = codes[n];
            mid_word[LetterW*n +: LetterW] = codes[n + int'(KEY_HALF)];
        end
        last_word = junk ? KeyW'({$urandom, $urandom}) : '0;
        len_word  = junk ? KeyW'({$urandom, $urandom}) : '0;
        last_word[LetterW-1:0] = codes[SqCells-1];
        len_word[LetterW-1:0]  = len_code;
        program_reg(REG_KEY_LOW, low_word);
        program_reg(REG_KEY_MID, mid_word);
        program_reg(REG_KEY_LAST, last_word);
        program_reg(REG_KEY_LEN, len_word);
    endtask

    task automatic program_keyword(input string kw);
        logic [LetterW-1:0] codes [SqCells];
        foreach (codes[n]) codes[n] = (n < kw.len()) ? LetterW'(kw[n] - UPPER_A) : '0;
        program_key(codes, LetterW'(kw.len()), 1'b0);
    endtask

    task automatic program_random_key(input logic [LetterW-1:0] len_code);
        logic [LetterW-1:0] codes [SqCells];
        foreach (codes[n]) begin
            case ($urandom_range(0, 7))
                0: codes[n] = LetterW'($urandom_range(Alpha, 31));
                1: codes[n] = LETTER_J;
                default: codes[n] = LetterW'($urandom_range(0, Alpha - 1));
            endcase
        end
        program_key(codes, len_code, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_pair(input logic [CharW-1:0] c1, input logic [CharW-1:0] c2);
        int unsigned gap;
        gap = tx_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, c2, c1};
        do @(posedge aclk); while (!s_tready);
        board.note_cipher_pair(c1, c2);
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i + 1 < txt.len(); i += 2)
            send_pair(CharW'(txt[i]), CharW'(txt[i+1]));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(negedge aclk);
    endtask

    // result side
    initial begin
        int unsigned gap;
        bit          held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold > 0 && !held) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(negedge aclk);
                held = 1'b1;
            end
            gap = rx_fast ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata);
            @(negedge aclk);
        end
    end

    initial begin
        logic [CharW-1:0] c1, c2;
        logic [LetterW-1:0] len_code;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        tx_fast   = 1'b0;
        rx_fast   = 1'b0;
        rx_hold   = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset key: plain alphabet square
        send_text("AZazZaAFABAGEAAVJIjjAAIk[aA`^_]z");
        wait_drained();
        program_keyword("PLAYFAIREXAMPLE");
        send_text("BModZUxhFY");
        wait_drained();
        program_random_key(5'd31);
        send_text("QwJjkT");
        wait_drained();
        // a write past the last register changes nothing
        program_reg(REG_NONE, KeyW'({$urandom, $urandom}));
        send_text("mN");
        wait_drained();

        for (int ph = 0; ph < int'(Phases); ph++) begin
            case (ph % 4)
                0: len_code = 5'd0;
                1: len_code = CELLS_MAX;
                2: len_code = 5'd31;
                default: len_code = LetterW'($urandom_range(1, 31));
            endcase
            if (ph % 3 == 2)
                program_reg(REG_KEY_LEN, KeyW'(len_code));
            else
                program_random_key(len_code);
            tx_fast = ($urandom_range(0, 2) == 0);
            rx_fast = ($urandom_range(0, 2) == 0);
            if (ph == 3) begin
                // receiver stalls long while input keeps coming
                tx_fast = 1'b1;
                rx_hold = 400;
            end
            for (int i = 0; i < int'(PhaseItems); i++) begin
                if (ph == 5 && i == PhaseItems / 2) wait_drained();
                c1 = rand_letter();
                c2 = rand_letter();
                case ($urandom_range(0, 19))
                    0: c1 = rand_other();
                    1: c2 = rand_other();
                    2: begin
                        c1 = rand_other();
                        c2 = rand_other();
                    end
                    3, 4: c2 = ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + (c1 -
                               ((c1 >= LOWER_A) ? LOWER_A : UPPER_A));
                    default: ;
                endcase
                send_pair(c1, c2);
            end
            wait_drained();
        end

        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
